### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL; empty bodies when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/shdmt_pkg.sv
// Types and constants of the string hash direct-mapped table.
`timescale 1ns / 1ps
`default_nettype none
package shdmt_pkg;

  localparam int HASH_W      = 32;
  localparam int KEY_W       = 8;
  localparam int CFG_W       = 11;
  localparam int VAL_PORT_W  = 32;
  localparam int SLOT_PORT_W = 10;
  localparam int STATUS_W    = 2;
  localparam int HASH_SHIFT  = 15;

  localparam logic [HASH_W-1:0] HASH_MULT  = 32'h5bd1_e995;
  localparam logic [CFG_W-1:0]  SIZE_RESET = 11'd1024;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLLISION = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIT       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS      = 2'd3;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

### hdl/shdmt_if.sv
// Valid/ready channel interfaces for key bytes in and results out.
`timescale 1ns / 1ps
`default_nettype none
interface shdmt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [shdmt_pkg::KEY_W-1:0]  key_byte;
  logic                         key_last;
  logic [shdmt_pkg::VAL_PORT_W-1:0] value_in;

  modport source (output valid, req_type, key_byte, key_last, value_in, input ready);
  modport sink   (input valid, req_type, key_byte, key_last, value_in, output ready);
endinterface

interface shdmt_out_if;
  logic                              valid;
  logic                              ready;
  logic [shdmt_pkg::STATUS_W-1:0]    status;
  logic [shdmt_pkg::VAL_PORT_W-1:0]  value_out;
  logic [shdmt_pkg::SLOT_PORT_W-1:0] slot_index;

  modport source (output valid, status, value_out, slot_index, input ready);
  modport sink   (input valid, status, value_out, slot_index, output ready);
endinterface
`default_nettype wire

### hdl/shdmt_mod_unit.sv
// Bit-serial remainder unit: hash modulo the clamped table size.
`timescale 1ns / 1ps
`default_nettype none
module shdmt_mod_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [shdmt_pkg::CFG_W-1:0]   size_cfg,
  input  shdmt_pkg::mod_req_t          req,
  output shdmt_pkg::mod_rsp_t          rsp
);
  import shdmt_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);
  localparam logic [31:0] DEPTH_U32 = TABLE_DEPTH;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  div_r, div_nxt;
  logic [CFG_W-1:0]  eff_size;
  logic [CFG_W:0]    trial;
  logic [CFG_W-1:0]  rem_step;

  // zero acts as one, anything past the depth saturates
  always_comb begin
    priority if (size_cfg == '0) begin
      eff_size = CFG_W'(1);
    end else if (32'(size_cfg) > DEPTH_U32) begin
      eff_size = DEPTH_U32[CFG_W-1:0];
    end else begin
      eff_size = size_cfg;
    end
  end

  // rem < div, so the shifted trial stays below twice the divisor
  always_comb begin
    trial = {rem_r, dvd_r[HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_step = CFG_W'(trial - {1'b0, div_r});
    end else begin
      rem_step = trial[CFG_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = eff_size;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

### hdl/string_hash_direct_mapped_table_top.sv
// Top level: byte hash, slot table memory and result register.
//
//  channel | dir | handshake        | payload
//  in_bus  | in  | valid/ready      | req_type, key_byte, key_last, value_in
//  out_bus | out | valid/ready      | status, value_out, slot_index
//  cfg     | in  | cfg_we           | cfg_wdata = table_size
//
// A non-last byte is multiplied on acceptance, then shift-xor mixed into the hash.
// A last byte goes through the same hash steps, 32 bit-serial remainder steps,
// a table read and a read-modify-write into the result register.
// After reset a clearing pass zeroes every slot to empty the table; no beat
// is taken meanwhile. The result register frees in_bus from out_bus stalls,
// except that a finished key waits while an earlier result is still unread.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module string_hash_direct_mapped_table_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire [shdmt_pkg::CFG_W-1:0] cfg_wdata,
  shdmt_in_if.sink                   in_bus,
  shdmt_out_if.source                out_bus
);
  import shdmt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MW    = VALUE_WIDTH + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MIX   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [HASH_W-1:0]      hash_r, hash_nxt;
  logic [CFG_W-1:0]       size_r;
  logic [IDX_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [HASH_W-1:0]      prod_r, prod_nxt;
  logic                   req_r, last_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [IDX_W-1:0]       slot_r;
  logic [MW-1:0]          rd_word_r;
  logic [STATUS_W-1:0]    out_status_r, status_nxt;
  logic [VAL_PORT_W-1:0]  out_value_r, value_nxt;
  logic [SLOT_PORT_W-1:0] out_slot_r;

  logic [MW-1:0]          mem [TABLE_DEPTH];
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [MW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       rem_idx;

  logic                   accept;
  logic                   out_free;
  logic                   resp_fire;
  logic [HASH_W-1:0]      mix_in;
  logic [HASH_W-1:0]      mixed;
  logic                   slot_occ;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign resp_fire    = (state_r == S_RESP) && out_free;

  assign mix_in   = hash_r ^ HASH_W'(in_bus.key_byte);
  assign prod_nxt = mix_in * HASH_MULT;
  assign mixed    = prod_r ^ (prod_r >> HASH_SHIFT);

  assign mod_req.start    = (state_r == S_MIX) && last_r;
  assign mod_req.dividend = mixed;

  shdmt_mod_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .size_cfg (size_r),
    .req      (mod_req),
    .rsp      (mod_rsp)
  );

  // remainder is below the clamped size, so it always fits the index
  assign rem_idx  = IDX_W'(mod_rsp.rem);
  assign mem_re   = (state_r == S_DIV) && mod_rsp.done;
  assign slot_occ = rd_word_r[VALUE_WIDTH];

  always_comb begin
    status_nxt = ST_MISS;
    value_nxt  = '0;
    if (req_r == REQ_INSERT) begin
      status_nxt = slot_occ ? ST_COLLISION : ST_INSERTED;
    end else if (slot_occ) begin
      status_nxt = ST_HIT;
      value_nxt  = VAL_PORT_W'(rd_word_r[VALUE_WIDTH-1:0]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = {1'b1, val_r};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (resp_fire && (req_r == REQ_INSERT) && !slot_occ) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (last_r) begin
          hash_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          hash_nxt  = mixed;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hash_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      size_r      <= SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= prod_nxt;
      req_r  <= in_bus.req_type;
      last_r <= in_bus.key_last;
      val_r  <= VALUE_WIDTH'(in_bus.value_in);
    end
    if (mem_re) begin
      slot_r <= rem_idx;
    end
    if (resp_fire) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
      out_slot_r   <= SLOT_PORT_W'(slot_r);
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_word_r <= mem[rem_idx];
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.value_out  = out_value_r;
  assign out_bus.slot_index = out_slot_r;

  `ASSERT_RST(a_resp_loads_out, clk, rst_n, resp_fire |=> out_valid_r)
  `ASSERT_NEVER(a_done_outside_div, clk, rst_n, mod_rsp.done && (state_r != S_DIV))
  `ASSERT_RST(a_hash_zero_per_key, clk, rst_n, (state_r == S_DIV) |-> (hash_r == '0))
  `ASSERT_NEVER(a_no_beat_in_clear, clk, rst_n, (state_r == S_CLEAR) && accept)

endmodule
`default_nettype wire
